[rtl/rhls_pkg.sv]
// ----------------------------------------------------------------------------
// rhls_pkg - shared types, constants and microcode for the region selector
// Beat types, control word layout, the sequencer program and the small
// arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package rhls_pkg;

    // hash constants
    localparam logic [63:0] GOLDEN     = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_K_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_K_B    = 64'h94d0_49bb_1331_11eb;
    // hash < this  <=>  hash rounded to double < 2^63
    localparam logic [63:0] CAND_LIMIT = 64'h7fff_ffff_ffff_fe00;

    // neighbourhood walk: index = dx*9 + dy*3 + dz, digits 0..2 mean -1..+1
    localparam int NBR_W = 5;
    localparam logic [NBR_W-1:0] NBR_CENTRE = 5'd13;
    localparam logic [NBR_W-1:0] NBR_LAST   = 5'd26;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] pc_t;

    // program labels
    localparam pc_t PC_WAIT   = 6'd0;
    localparam pc_t PC_LOOP   = 6'd1;
    localparam pc_t PC_NOCAND = 6'd31;
    localparam pc_t PC_ADV    = 6'd32;
    localparam pc_t PC_DONE   = 6'd34;

    typedef struct packed {
        logic signed [31:0] region_x;
        logic signed [31:0] region_y;
        logic signed [31:0] region_z;
    } in_beat_t;

    typedef struct packed {
        logic is_candidate;
        logic is_selected;
    } out_beat_t;

    typedef enum logic [3:0] {
        ACT_NOP, ACT_WAIT, ACT_LDC, ACT_IN, ACT_XM, ACT_SUM,
        ACT_FIN, ACT_RKEY, ACT_KEY, ACT_ADV, ACT_EMIT
    } act_t;

    typedef enum logic {SRC_SEED, SRC_H} src_t;

    typedef enum logic [2:0] {
        OPND_X, OPND_Y, OPND_Z, OPND_SALT0, OPND_SALT1
    } opnd_t;

    typedef enum logic {KSEL_A, KSEL_B} ksel_t;

    typedef enum logic {DEST_H, DEST_RES} dest_t;

    typedef enum logic [2:0] {
        COND_NEVER, COND_ALWAYS, COND_NOT_START, COND_NOT_CAND,
        COND_IS_CENTRE, COND_SEL_CLEAR, COND_LAST, COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        src_t  src;
        opnd_t opnd;
        ksel_t ksel;
        dest_t dest;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic not_cand;
        logic centre;
        logic sel_clear;
        logic last;
        logic out_busy;
    } flags_t;

    function automatic ctrl_t w_ctl(act_t a, cond_t c, pc_t t);
        ctrl_t w;
        w.act    = a;
        w.src    = SRC_H;
        w.opnd   = OPND_SALT0;
        w.ksel   = KSEL_A;
        w.dest   = DEST_H;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic ctrl_t w_in(src_t s, opnd_t o);
        ctrl_t w;
        w      = w_ctl(ACT_IN, COND_NEVER, PC_WAIT);
        w.src  = s;
        w.opnd = o;
        return w;
    endfunction

    function automatic ctrl_t w_xm(ksel_t k);
        ctrl_t w;
        w      = w_ctl(ACT_XM, COND_NEVER, PC_WAIT);
        w.ksel = k;
        return w;
    endfunction

    function automatic ctrl_t w_fin(dest_t d);
        ctrl_t w;
        w      = w_ctl(ACT_FIN, COND_NEVER, PC_WAIT);
        w.dest = d;
        return w;
    endfunction

    // sequencer program; each mix is IN, XM(A), SUM, XM(B), FIN
    function automatic ctrl_t ucode(pc_t pc);
        ctrl_t w;
        unique case (pc)
            6'd0:  w = w_ctl(ACT_WAIT, COND_NOT_START, PC_WAIT);
            6'd1:  w = w_ctl(ACT_LDC, COND_NEVER, PC_WAIT);
            6'd2:  w = w_in(SRC_SEED, OPND_X);
            6'd3:  w = w_xm(KSEL_A);
            6'd4:  w = w_ctl(ACT_SUM, COND_NEVER, PC_WAIT);
            6'd5:  w = w_xm(KSEL_B);
            6'd6:  w = w_fin(DEST_H);
            6'd7:  w = w_in(SRC_H, OPND_Y);
            6'd8:  w = w_xm(KSEL_A);
            6'd9:  w = w_ctl(ACT_SUM, COND_NEVER, PC_WAIT);
            6'd10: w = w_xm(KSEL_B);
            6'd11: w = w_fin(DEST_H);
            6'd12: w = w_in(SRC_H, OPND_Z);
            6'd13: w = w_xm(KSEL_A);
            6'd14: w = w_ctl(ACT_SUM, COND_NEVER, PC_WAIT);
            6'd15: w = w_xm(KSEL_B);
            6'd16: w = w_fin(DEST_H);
            6'd17: w = w_in(SRC_H, OPND_SALT0);
            6'd18: w = w_xm(KSEL_A);
            6'd19: w = w_ctl(ACT_SUM, COND_NEVER, PC_WAIT);
            6'd20: w = w_xm(KSEL_B);
            6'd21: w = w_fin(DEST_RES);
            6'd22: w = w_ctl(ACT_NOP, COND_NOT_CAND, PC_NOCAND);
            6'd23: w = w_in(SRC_H, OPND_SALT1);
            6'd24: w = w_xm(KSEL_A);
            6'd25: w = w_ctl(ACT_SUM, COND_NEVER, PC_WAIT);
            6'd26: w = w_xm(KSEL_B);
            6'd27: w = w_fin(DEST_RES);
            6'd28: w = w_ctl(ACT_RKEY, COND_NEVER, PC_WAIT);
            6'd29: w = w_ctl(ACT_KEY, COND_IS_CENTRE, PC_ADV);
            6'd30: w = w_ctl(ACT_NOP, COND_SEL_CLEAR, PC_DONE);
            6'd31: w = w_ctl(ACT_NOP, COND_IS_CENTRE, PC_DONE);
            6'd32: w = w_ctl(ACT_ADV, COND_LAST, PC_DONE);
            6'd33: w = w_ctl(ACT_NOP, COND_ALWAYS, PC_LOOP);
            6'd34: w = w_ctl(ACT_EMIT, COND_OUT_BUSY, PC_DONE);
            6'd35: w = w_ctl(ACT_NOP, COND_ALWAYS, PC_WAIT);
            default: w = w_ctl(ACT_NOP, COND_ALWAYS, PC_WAIT);
        endcase
        return w;
    endfunction

    // {dx, dy, dz} digits of a neighbourhood index
    function automatic logic [5:0] nbr_digits(logic [NBR_W-1:0] idx);
        logic [NBR_W-1:0] r;
        logic [1:0]       dx;
        logic [1:0]       dy;
        if (idx >= 5'd18) begin
            dx = 2'd2;
            r  = idx - 5'd18;
        end else if (idx >= 5'd9) begin
            dx = 2'd1;
            r  = idx - 5'd9;
        end else begin
            dx = 2'd0;
            r  = idx;
        end
        if (r >= 5'd6) begin
            dy = 2'd2;
            r  = r - 5'd6;
        end else if (r >= 5'd3) begin
            dy = 2'd1;
            r  = r - 5'd3;
        end else begin
            dy = 2'd0;
        end
        return {dx, dy, r[1:0]};
    endfunction

    // coordinate plus -1 / 0 / +1, wrapping
    function automatic logic [31:0] coord_step(logic [31:0] c, logic [1:0] d);
        logic [31:0] r;
        unique case (d)
            2'd0:    r = c - 32'd1;
            2'd2:    r = c + 32'd1;
            default: r = c;
        endcase
        return r;
    endfunction

    // value rounded to a 53-bit significand, ties to even, as a 65-bit integer
    function automatic logic [64:0] round53(logic [63:0] h);
        logic [3:0]  s;
        logic [63:0] mask;
        logic [63:0] half;
        logic [63:0] rem;
        logic        up;
        s = 4'd0;
        for (int i = 53; i < 64; i++) begin
            if (h[i]) s = 4'(i - 52);
        end
        mask = (64'd1 << s) - 64'd1;
        half = (mask >> 1) + 64'd1;
        rem  = h & mask;
        up   = (rem > half) || ((rem == half) && (|(h & (mask + 64'd1))));
        return {1'b0, h & ~mask} + (up ? ({1'b0, mask} + 65'd1) : 65'd0);
    endfunction

endpackage

[rtl/rhls_seq.sv]
// ----------------------------------------------------------------------------
// rhls_seq - microcode sequencer
// Step counter over the program ROM with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module rhls_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  rhls_pkg::flags_t flags,
    output rhls_pkg::ctrl_t  ctrl
);

    rhls_pkg::pc_t pc_reg;
    rhls_pkg::pc_t pc_next;
    logic          take;

    assign ctrl = rhls_pkg::ucode(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            rhls_pkg::COND_NEVER:     take = 1'b0;
            rhls_pkg::COND_ALWAYS:    take = 1'b1;
            rhls_pkg::COND_NOT_START: take = !flags.start;
            rhls_pkg::COND_NOT_CAND:  take = flags.not_cand;
            rhls_pkg::COND_IS_CENTRE: take = flags.centre;
            rhls_pkg::COND_SEL_CLEAR: take = flags.sel_clear;
            rhls_pkg::COND_LAST:      take = flags.last;
            rhls_pkg::COND_OUT_BUSY:  take = flags.out_busy;
            default:                  take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 6'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rhls_pkg::PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/region_hash_local_max_select_top.sv]
// ----------------------------------------------------------------------------
// region_hash_local_max_select_top - local-maximum feature selector
// Hashes a 3-D region and its 26 neighbours with a seeded splitmix64 chain
// and reports whether the region is a candidate and a local priority maximum.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              beat / payload
//  s_        in   s_valid / s_ready      in_beat_t  {region_x, region_y, region_z}
//  m_        out  m_valid / m_ready      out_beat_t {is_candidate, is_selected}
//  cfg_      in   cfg_wr_en (no wait)    world_seed, 32 bit
//
//  One beat at a time, worked through by the shared mix datapath: 5 steps
//  per splitmix64 round, 5 rounds per region (4 for a non-candidate), up
//  to 27 regions, plus loop overhead.
//  The walk stops early once a neighbour beats the centre.
//  Reset is synchronous, active low; seed returns to 0. A finished result
//  sits in the output register while the next beat is accepted; a stalled
//  m_ready only holds the sequencer if a second result is ready to go.
//
module region_hash_local_max_select_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rhls_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rhls_pkg::out_beat_t  m_data
);

    rhls_pkg::ctrl_t  ctrl;
    rhls_pkg::flags_t flags;

    logic [31:0]          seed_reg;
    rhls_pkg::in_beat_t   crd_reg;
    logic [4:0]           off_reg;
    logic [4:0]           off_next;
    logic [4:0]           off_plus;
    logic [31:0]          cx_reg;
    logic [31:0]          cy_reg;
    logic [31:0]          cz_reg;
    logic [63:0]          h_reg;       // chain value (h3 once z is folded in)
    logic [63:0]          v_reg;       // working value inside one mix
    logic [63:0]          res_reg;     // salted hash
    logic [63:0]          p_ll_reg;
    logic [31:0]          p_hl_reg;
    logic [31:0]          p_lh_reg;
    logic [64:0]          rk_reg;      // rounded priority of current region
    logic [64:0]          mine_reg;    // rounded priority of centre
    logic                 cand_reg;
    logic                 sel_reg;
    logic                 m_valid_reg;
    rhls_pkg::out_beat_t  m_data_reg;

    logic [63:0] mix_src;
    logic [63:0] opnd_val;
    logic [63:0] mix_in;
    logic [63:0] xs;
    logic [63:0] kmul;
    logic [63:0] prod_ll;
    logic [31:0] prod_hl;
    logic [31:0] prod_lh;
    logic [63:0] sum;
    logic [63:0] fin;
    logic [5:0]  digits;
    logic        is_centre;
    logic        out_busy;
    logic        emit;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    rhls_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign is_centre = (off_reg == rhls_pkg::NBR_CENTRE);
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit      = (ctrl.act == rhls_pkg::ACT_EMIT) && !out_busy;

    always_comb begin
        flags.start     = s_valid;
        flags.not_cand  = !(res_reg < rhls_pkg::CAND_LIMIT);
        flags.centre    = is_centre;
        flags.sel_clear = !sel_reg;
        flags.last      = (off_reg == rhls_pkg::NBR_LAST);
        flags.out_busy  = out_busy;
    end

    // ------------------------------------------------------------------
    // mix datapath: three 32x32 partial products per 64-bit multiply,
    // registered, then summed in the following step
    // ------------------------------------------------------------------
    assign mix_src = (ctrl.src == rhls_pkg::SRC_SEED) ? {32'd0, seed_reg} : h_reg;

    always_comb begin
        unique case (ctrl.opnd)
            rhls_pkg::OPND_X:     opnd_val = {{32{cx_reg[31]}}, cx_reg};
            rhls_pkg::OPND_Y:     opnd_val = {{32{cy_reg[31]}}, cy_reg};
            rhls_pkg::OPND_Z:     opnd_val = {{32{cz_reg[31]}}, cz_reg};
            rhls_pkg::OPND_SALT1: opnd_val = 64'd1;
            default:              opnd_val = 64'd0;
        endcase
    end

    assign mix_in  = (mix_src ^ opnd_val) + rhls_pkg::GOLDEN;
    assign xs      = (ctrl.ksel == rhls_pkg::KSEL_A) ? (v_reg ^ (v_reg >> 30))
                                                     : (v_reg ^ (v_reg >> 27));
    assign kmul    = (ctrl.ksel == rhls_pkg::KSEL_A) ? rhls_pkg::MIX_K_A
                                                     : rhls_pkg::MIX_K_B;
    assign prod_ll = {32'd0, xs[31:0]} * {32'd0, kmul[31:0]};
    assign prod_hl = xs[63:32] * kmul[31:0];
    assign prod_lh = xs[31:0] * kmul[63:32];
    assign sum     = p_ll_reg + {p_hl_reg + p_lh_reg, 32'd0};
    assign fin     = sum ^ (sum >> 31);

    // neighbour walk: centre first, then 0..26 skipping the centre
    assign digits   = rhls_pkg::nbr_digits(off_reg);
    assign off_plus = off_reg + 5'd1;
    assign off_next = is_centre ? 5'd0
                    : ((off_plus == rhls_pkg::NBR_CENTRE) ? off_reg + 5'd2 : off_plus);

    // ------------------------------------------------------------------
    // datapath registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (ctrl.act)
            rhls_pkg::ACT_WAIT: begin
                if (s_valid) begin
                    crd_reg  <= s_data;
                    off_reg  <= rhls_pkg::NBR_CENTRE;
                    cand_reg <= 1'b0;
                    sel_reg  <= 1'b0;
                end
            end
            rhls_pkg::ACT_LDC: begin
                cx_reg <= rhls_pkg::coord_step(crd_reg.region_x, digits[5:4]);
                cy_reg <= rhls_pkg::coord_step(crd_reg.region_y, digits[3:2]);
                cz_reg <= rhls_pkg::coord_step(crd_reg.region_z, digits[1:0]);
            end
            rhls_pkg::ACT_IN: begin
                v_reg <= mix_in;
            end
            rhls_pkg::ACT_XM: begin
                p_ll_reg <= prod_ll;
                p_hl_reg <= prod_hl;
                p_lh_reg <= prod_lh;
            end
            rhls_pkg::ACT_SUM: begin
                v_reg <= sum;
            end
            rhls_pkg::ACT_FIN: begin
                if (ctrl.dest == rhls_pkg::DEST_H) begin
                    h_reg <= fin;
                end else begin
                    res_reg <= fin;
                end
            end
            rhls_pkg::ACT_RKEY: begin
                rk_reg <= rhls_pkg::round53(res_reg);
            end
            rhls_pkg::ACT_KEY: begin
                if (is_centre) begin
                    mine_reg <= rk_reg;
                    cand_reg <= 1'b1;
                    sel_reg  <= 1'b1;
                end else if (rk_reg > mine_reg) begin
                    sel_reg <= 1'b0;
                end
            end
            rhls_pkg::ACT_ADV: begin
                off_reg <= off_next;
            end
            default: begin
            end
        endcase
        if (emit) begin
            m_data_reg.is_candidate <= cand_reg;
            m_data_reg.is_selected  <= sel_reg;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (ctrl.act == rhls_pkg::ACT_WAIT);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_sel_needs_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.is_selected || m_data_reg.is_candidate))
        else $error("selected result without candidate");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted while busy");

    a_round_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ((ctrl.act == rhls_pkg::ACT_KEY) && rk_reg[64]) |-> (rk_reg[63:0] == 64'd0))
        else $error("rounded priority beyond 2^64");

endmodule

[verif/tb_region_select_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_region_select_checker - verdict predictor and result comparator
// Watches the seed port and both channels, works out the candidate and
// selection verdict of every accepted region and compares it with the
// result beats in order.
// ----------------------------------------------------------------------------
module tb_region_select_checker
    import rhls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_beat_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_beat_t   m_data,
    output int          mismatches,
    output int          outstanding,
    output int          cand_seen,
    output int          sel_seen
);

    localparam logic [63:0] SM_GAMMA   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SM_MUL1    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] SM_MUL2    = 64'h94d0_49bb_1331_11eb;
    localparam logic [63:0] CAND_BOUND = 64'h7fff_ffff_ffff_fe00;
    localparam logic [63:0] SALT_CAND  = 64'd0;
    localparam logic [63:0] SALT_PRIO  = 64'd1;

    typedef struct {
        in_beat_t  region;
        out_beat_t verdict;
    } verdict_rec_t;

    verdict_rec_t verdict_q[$];
    logic [63:0]  seed_shadow = 64'd0;

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] t;
        t = v + SM_GAMMA;
        t = (t ^ (t >> 30)) * SM_MUL1;
        t = (t ^ (t >> 27)) * SM_MUL2;
        return t ^ (t >> 31);
    endfunction

    // seeded chain over the sign-extended coordinate, then the salt
    function automatic logic [63:0] region_hash(input logic [63:0] seed,
                                                input logic [31:0] x,
                                                input logic [31:0] y,
                                                input logic [31:0] z,
                                                input logic [63:0] salt);
        logic [63:0] h;
        h = splitmix(seed ^ {{32{x[31]}}, x});
        h = splitmix(h ^ {{32{y[31]}}, y});
        h = splitmix(h ^ {{32{z[31]}}, z});
        return splitmix(h ^ salt);
    endfunction

    // order-preserving key of h rounded to 53 significant bits, ties to even
    function automatic logic [63:0] priority_key(input logic [63:0] h);
        int          top_bit;
        int          sh;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        if (h < (64'd1 << 53))
            return h;
        top_bit = 63;
        while (!h[top_bit])
            top_bit--;
        sh   = top_bit - 52;
        kept = h >> sh;
        rem  = h & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 64'd1;
        if (kept == (64'd1 << 53)) begin
            kept = kept >> 1;
            sh++;
        end
        return (64'(sh) << 53) + kept;
    endfunction

    function automatic logic is_candidate_at(input logic [63:0] seed, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z);
        return region_hash(seed, x, y, z, SALT_CAND) < CAND_BOUND;
    endfunction

    function automatic out_beat_t predict_verdict(input logic [63:0] seed, input in_beat_t r);
        out_beat_t   v;
        logic [63:0] own_key;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        v.is_candidate = is_candidate_at(seed, r.region_x, r.region_y, r.region_z);
        v.is_selected  = v.is_candidate;
        if (v.is_candidate) begin
            own_key = priority_key(region_hash(seed, r.region_x, r.region_y, r.region_z,
                                               SALT_PRIO));
            for (int dx = -1; dx <= 1; dx++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dz = -1; dz <= 1; dz++) begin
                        // neighbours wrap modulo 2^32; equal keys do not block
                        nx = r.region_x + 32'(dx);
                        ny = r.region_y + 32'(dy);
                        nz = r.region_z + 32'(dz);
                        if ((dx != 0 || dy != 0 || dz != 0)
                            && is_candidate_at(seed, nx, ny, nz)
                            && priority_key(region_hash(seed, nx, ny, nz, SALT_PRIO))
                               > own_key)
                            v.is_selected = 1'b0;
                    end
                end
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin : watch
        verdict_rec_t rec;
        int           bad;
        bad = 0;
        if (!aresetn) begin
            seed_shadow <= 64'd0;
            verdict_q.delete();
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready) begin
                rec.region  = s_data;
                rec.verdict = predict_verdict(seed_shadow, s_data);
                verdict_q.push_back(rec);
            end
            if (cfg_wr_en)
                seed_shadow <= {32'd0, cfg_wr_data};
            if (m_valid && m_ready) begin
                cand_seen <= cand_seen + int'(m_data.is_candidate);
                sel_seen  <= sel_seen + int'(m_data.is_selected);
                if (verdict_q.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding: cand=%0b sel=%0b",
                             $time, m_data.is_candidate, m_data.is_selected);
                    bad++;
                end else begin
                    rec = verdict_q.pop_front();
                    if (m_data.is_candidate !== rec.verdict.is_candidate) begin
                        $display("%0t: is_candidate at (%0d,%0d,%0d): expected %0b, got %0b",
                                 $time, rec.region.region_x, rec.region.region_y,
                                 rec.region.region_z, rec.verdict.is_candidate,
                                 m_data.is_candidate);
                        bad++;
                    end
                    if (m_data.is_selected !== rec.verdict.is_selected) begin
                        $display("%0t: is_selected at (%0d,%0d,%0d): expected %0b, got %0b",
                                 $time, rec.region.region_x, rec.region.region_y,
                                 rec.region.region_z, rec.verdict.is_selected,
                                 m_data.is_selected);
                        bad++;
                    end
                end
            end
            mismatches  <= mismatches + bad;
            outstanding <= verdict_q.size();
        end
    end

endmodule

[verif/tb_region_hash_local_max_select_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_region_hash_local_max_select_top - testbench for the region selector
// Drives region beats under a series of world seeds, throttles both sides
// at random, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_region_hash_local_max_select_top;
    import rhls_pkg::*;

    // per-seed share of the random beats; five seed settings after the
    // directed set gives roughly 450 beats in all
    localparam int RANDOM_PER_SEED = 86;
    localparam int SEED_SETTINGS   = 5;
    localparam int IDLE_PCT        = 37;
    // receiver hold-off: long enough for a couple of full neighbourhood
    // walks, so the output register and the sequencer both fill
    localparam int HOLD_CYCLES     = 2000;
    // well above the hold-off plus one worst-case walk
    localparam int STALL_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int DRAIN_CYCLES    = 1000;

    localparam logic [31:0] C_MAX = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN = 32'h8000_0000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    // shared throttle controls, always written with nonblocking assignments
    logic      steady;
    logic      hold_req;

    int        mismatches;
    int        outstanding;
    int        cand_seen;
    int        sel_seen;
    int        beats_sent  = 0;
    int        seed_loads  = 0;
    int        stall_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    region_hash_local_max_select_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    tb_region_select_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .cand_seen   (cand_seen),
        .sel_seen    (sel_seen)
    );

    // watchdog: a stretch with no beat moving on either side that reaches the stall limit ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random back-pressure, none during the steady stretch,
    // and one long hold-off on request while the sender keeps offering
    initial begin : sink
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic in_beat_t region_at(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
        in_beat_t r;
        r.region_x = x;
        r.region_y = y;
        r.region_z = z;
        return r;
    endfunction

    // a coordinate within two of either end of the range, or from -3 to 2
    function automatic logic [31:0] edge_coord();
        logic [31:0] r;
        r = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
            0:       return C_MAX - r;
            1:       return C_MIN + r;
            2:       return r;
            default: return 32'hffff_ffff - r;
        endcase
    endfunction

    // about a third of the time walks to a neighbouring region, so candidates meet their
    // rivals; the rest is scattered, near the range ends or near the origin
    function automatic in_beat_t next_region(input in_beat_t prev);
        in_beat_t r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            r = region_at($urandom, $urandom, $urandom);
        end else if (pick < 70) begin
            r = region_at(prev.region_x + 32'($urandom_range(0, 2)) - 32'd1,
                          prev.region_y + 32'($urandom_range(0, 2)) - 32'd1,
                          prev.region_z + 32'($urandom_range(0, 2)) - 32'd1);
        end else if (pick < 85) begin
            r = region_at(edge_coord(), edge_coord(), edge_coord());
        end else begin
            r = region_at(32'($urandom_range(0, 15)) - 32'd8,
                          32'($urandom_range(0, 15)) - 32'd8,
                          32'($urandom_range(0, 15)) - 32'd8);
        end
        return r;
    endfunction

    // valid stays up straight into the next beat unless an idle gap is taken
    task automatic offer_region(input in_beat_t r);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
    endtask

    // park the sender and wait for every outstanding verdict
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // seed writes only with the block idle
    task automatic load_seed(input logic [31:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        seed_loads++;
    endtask

    initial begin : stimulus
        in_beat_t    walk;
        logic [31:0] seed_plan [SEED_SETTINGS];

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 32'd0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        steady      <= 1'b0;
        hold_req    <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed set under the reset seed, written explicitly
        load_seed(32'd0);
        offer_region(region_at(32'd0, 32'd0, 32'd0));
        offer_region(region_at(32'd1, 32'd0, 32'd0));
        offer_region(region_at(32'd0, 32'd1, 32'd0));
        offer_region(region_at(32'd0, 32'd0, 32'd1));
        offer_region(region_at(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        offer_region(region_at(32'hffff_ffff, 32'd0, 32'd1));
        // range ends: neighbours wrap from the top to the bottom and back
        offer_region(region_at(C_MAX, C_MAX, C_MAX));
        offer_region(region_at(C_MIN, C_MIN, C_MIN));
        offer_region(region_at(C_MAX, C_MIN, 32'd0));
        offer_region(region_at(C_MIN, C_MAX, 32'hffff_ffff));
        offer_region(region_at(32'd0, C_MAX, C_MIN));
        offer_region(region_at(C_MIN, 32'd0, C_MAX));
        offer_region(region_at(C_MAX, 32'hffff_ffff, C_MIN));
        offer_region(region_at(C_MAX - 32'd1, C_MIN + 32'd1, C_MAX));
        // alternating and other bit patterns, then small coordinates
        offer_region(region_at(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
        offer_region(region_at(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
        offer_region(region_at(32'h0000_ffff, 32'hffff_0000, 32'h00ff_ff00));
        offer_region(region_at(32'd2, 32'd2, 32'd2));
        offer_region(region_at(32'd3, 32'd2, 32'd1));

        // all ones, a single top bit, a single low bit and random values
        seed_plan[0] = 32'hffff_ffff;
        seed_plan[1] = 32'h8000_0000;
        seed_plan[2] = $urandom;
        seed_plan[3] = 32'd1;
        seed_plan[4] = $urandom;

        walk = region_at($urandom, $urandom, $urandom);
        for (int p = 0; p < SEED_SETTINGS; p++) begin
            load_seed(seed_plan[p]);
            for (int i = 0; i < RANDOM_PER_SEED; i++) begin
                // steady stretch: neither side idles
                if (p == 1 && i == 10)
                    steady <= 1'b1;
                if (p == 1 && i == 60)
                    steady <= 1'b0;
                // long receiver hold-off while beats keep coming
                if (p == 2 && i == 20)
                    hold_req <= 1'b1;
                // sender pause until the pipe is empty
                if (p == 3 && i == 40)
                    wait_drained();
                walk = next_region(walk);
                offer_region(walk);
            end
        end

        wait_drained();
        // quiet tail: anything arriving now has no expectation behind it
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d region beats under %0d seed loads (zero, all ones, top bit, random)",
                 beats_sent, seed_loads);
        $display("run: %0d candidates, %0d selected; hold-off and drained pause included",
                 cand_seen, sel_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
